/* design/emd_pkg.sv */
// ----------------------------------------------------------------------------
// emd_pkg: shared constants and types for the ECG median-5 decimator
// Widths, divider constants and the types passed between lanes, converters
// and the merge stage.
// ----------------------------------------------------------------------------
package emd_pkg;

  localparam int N_LANES  = 3;
  localparam int DECIM    = 4;
  localparam int CODE_W   = 24;
  localparam int UV_W     = 22;
  localparam int SUM_W    = 28;
  localparam int LO_W     = 8;
  localparam int IDX_W    = 32;
  localparam int WIN_LEN  = 5;
  localparam int PTR_W    = $clog2(WIN_LEN);
  localparam int PHASE_W  = (DECIM > 1) ? $clog2(DECIM) : 1;

  localparam logic [CODE_W-1:0] MIDSCALE = CODE_W'(6400000);

  // code sum to microvolts: (3*sum - UV_OFFSET) / UV_DIV, truncated toward zero
  localparam int UV_OFFSET = 19200000 * DECIM;
  localparam int UV_DIV    = 28 * DECIM;
  localparam int UV_SHIFT  = 32;
  localparam int UV_RCP_W  = 28;
  localparam longint unsigned UV_RECIP = (64'd1 << UV_SHIFT) / UV_DIV;
  localparam int NUM_W     = SUM_W + 3;
  localparam int MAG_W     = SUM_W + 2;
  localparam int UPROD_W   = MAG_W + UV_RCP_W;
  localparam int UQ_W      = UPROD_W - UV_SHIFT;
  localparam int UREM_W    = $clog2(2 * UV_DIV);

  // three-channel mean
  localparam int S_W         = UV_W + 2;
  localparam int MS_W        = UV_W + 1;
  localparam int MEAN_RCP_W  = MS_W - 1;
  localparam longint unsigned MEAN_RECIP = (64'd1 << MS_W) / N_LANES;
  localparam int MPROD_W     = MS_W + MEAN_RCP_W;
  localparam int MQ_W        = MPROD_W - MS_W;
  localparam int MREM_W      = $clog2(2 * N_LANES);

  // stream packing
  localparam int IN_W  = ((N_LANES * CODE_W + LO_W + 7) / 8) * 8;
  localparam int OUT_W = ((4 * UV_W + LO_W + IDX_W + 7) / 8) * 8;

  // pipeline: window, median, sum, 4 conversion stages, 4 mean stages
  localparam int PIPE_DEPTH = 11;
  localparam int STG_MED    = 2;
  localparam int STG_UV     = 7;

  typedef struct packed {
    logic adv;
    logic wr;
    logic acc;
    logic clr;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [UV_W-1:0] ch1;
    logic signed [UV_W-1:0] ch2;
    logic signed [UV_W-1:0] ch3;
    logic signed [UV_W-1:0] mean;
  } uv_res_t;

endpackage

/* design/emd_lane.sv */
// ----------------------------------------------------------------------------
// emd_lane: one channel lane
// Five-entry circular window, registered median of five, and the boxcar
// accumulator that hands its total on at the decimation point.
// ----------------------------------------------------------------------------
module emd_lane import emd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctl_t         ctl_i,
  input  logic [CODE_W-1:0] code_i,
  output logic [SUM_W-1:0]  tot_o
);

  logic [CODE_W-1:0] win_q [WIN_LEN];
  logic [PTR_W-1:0]  ptr_q;
  logic [CODE_W-1:0] med, med_q;
  logic [SUM_W-1:0]  sum_q, tot_q, total;

  function automatic logic [CODE_W-1:0] min2(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CODE_W-1:0] max2(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  // drop the min and max of the first four, then median of three
  always_comb begin
    logic [CODE_W-1:0] lo_a, lo_b, hi_a, hi_b, x, y;
    lo_a = min2(win_q[0], win_q[1]);
    hi_a = max2(win_q[0], win_q[1]);
    lo_b = min2(win_q[2], win_q[3]);
    hi_b = max2(win_q[2], win_q[3]);
    x    = max2(lo_a, lo_b);
    y    = min2(hi_a, hi_b);
    med  = max2(min2(x, y), min2(max2(x, y), win_q[4]));
  end

  assign total = sum_q + (ctl_i.acc ? SUM_W'(med_q) : SUM_W'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= MIDSCALE;
      end
      ptr_q <= '0;
      sum_q <= '0;
    end else begin
      if (ctl_i.wr) begin
        win_q[ptr_q] <= code_i;
        ptr_q        <= (ptr_q == PTR_W'(WIN_LEN - 1)) ? '0 : ptr_q + 1'b1;
      end
      if (ctl_i.adv && (ctl_i.acc || ctl_i.clr)) begin
        sum_q <= ctl_i.clr ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      med_q <= med;
      tot_q <= total;
    end
  end

  assign tot_o = tot_q;

endmodule

/* design/emd_uv_conv.sv */
// ----------------------------------------------------------------------------
// emd_uv_conv: code sum to microvolts
// (3*sum - offset) / div truncated toward zero, by reciprocal multiply and
// one remainder correction over four stages.
// ----------------------------------------------------------------------------
module emd_uv_conv import emd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   adv_i,
  input  logic [SUM_W-1:0]       tot_i,
  output logic signed [UV_W-1:0] uv_o
);

  logic [NUM_W-1:0]        x3;
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0]        mag_d, mag_a_q, mag_b_q, qd;
  logic                    neg_a_q, neg_b_q, neg_c_q;
  logic [UPROD_W-1:0]      prod_q;
  logic [UQ_W-1:0]         q0, q0_q, q, qs;
  logic [UREM_W-1:0]       rem_q;
  logic signed [UV_W-1:0]  uv_q;

  assign x3    = (NUM_W'(tot_i) << 1) + NUM_W'(tot_i);
  assign num   = $signed(x3) - $signed(NUM_W'(UV_OFFSET));
  assign mag_d = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);

  assign q0 = prod_q[UPROD_W-1:UV_SHIFT];
  assign qd = MAG_W'(q0) * MAG_W'(UV_DIV);

  assign q  = q0_q + UQ_W'(rem_q >= UREM_W'(UV_DIV));
  assign qs = neg_c_q ? (UQ_W'(0) - q) : q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag_a_q <= mag_d;
      neg_a_q <= num[NUM_W-1];
      prod_q  <= UPROD_W'(mag_a_q) * UPROD_W'(UV_RECIP);
      mag_b_q <= mag_a_q;
      neg_b_q <= neg_a_q;
      q0_q    <= q0;
      rem_q   <= UREM_W'(mag_b_q - qd);
      neg_c_q <= neg_b_q;
      uv_q    <= $signed(qs[UV_W-1:0]);
    end
  end

  assign uv_o = uv_q;

endmodule

/* design/emd_merge.sv */
// ----------------------------------------------------------------------------
// emd_merge: lane merge and mean
// Sums the channel values, divides by three toward zero, and registers the
// result word. Two-channel mode zeroes channel 3 and passes channel 2 as mean.
// ----------------------------------------------------------------------------
module emd_merge import emd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   adv_i,
  input  logic                   two_i,
  input  logic signed [UV_W-1:0] uv_i [N_LANES],
  output uv_res_t                res_o
);

  logic signed [UV_W-1:0] uv3z;
  logic signed [S_W-1:0]  s;
  logic [MS_W-1:0]        mag_d, mag_e_q, mag_f_q;
  logic signed [UV_W-1:0] uv_e_q [N_LANES];
  logic signed [UV_W-1:0] uv_f_q [N_LANES];
  logic signed [UV_W-1:0] uv_g_q [N_LANES];
  logic                   two_e_q, two_f_q, two_g_q;
  logic                   neg_e_q, neg_f_q, neg_g_q;
  logic [MPROD_W-1:0]     prod_f_q;
  logic [MQ_W-1:0]        q0, q0_g_q, q, qs;
  logic [MREM_W-1:0]      rem_g_q;
  logic signed [UV_W-1:0] mean;
  uv_res_t                res_q;

  assign uv3z  = two_i ? '0 : uv_i[2];
  assign s     = S_W'(uv_i[0]) + S_W'(uv_i[1]) + S_W'(uv3z);
  assign mag_d = s[S_W-1] ? MS_W'(-s) : MS_W'(s);

  assign q0 = prod_f_q[MPROD_W-1:MS_W];

  assign q    = q0_g_q + MQ_W'(rem_g_q >= MREM_W'(N_LANES));
  assign qs   = neg_g_q ? (MQ_W'(0) - q) : q;
  assign mean = two_g_q ? uv_g_q[1] : $signed(qs[UV_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      uv_e_q[0] <= uv_i[0];
      uv_e_q[1] <= uv_i[1];
      uv_e_q[2] <= uv3z;
      two_e_q   <= two_i;
      neg_e_q   <= s[S_W-1];
      mag_e_q   <= mag_d;

      uv_f_q    <= uv_e_q;
      two_f_q   <= two_e_q;
      neg_f_q   <= neg_e_q;
      mag_f_q   <= mag_e_q;
      prod_f_q  <= MPROD_W'(mag_e_q) * MPROD_W'(MEAN_RECIP);

      uv_g_q    <= uv_f_q;
      two_g_q   <= two_f_q;
      neg_g_q   <= neg_f_q;
      q0_g_q    <= q0;
      rem_g_q   <= MREM_W'(mag_f_q - (MS_W'(q0) * MS_W'(N_LANES)));

      res_q     <= '{ch1: uv_g_q[0], ch2: uv_g_q[1], ch3: uv_g_q[2], mean: mean};
    end
  end

  assign res_o = res_q;

endmodule

/* design/ecg_median5_decimator.sv */
// ----------------------------------------------------------------------------
// ecg_median5_decimator: three-lane median-5 filter with boxcar decimation
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  ADC codes and lead-off byte
//   m_axis    out  m_axis_tvalid / m_axis_tready  microvolts, lead-off, index
//   cfg       in   cfg_valid_i / cfg_ready_o      two_channel_mode
//
// One sample per cycle while no result waits unclaimed; results appear every
// DECIM-th sample, at the end of the pipeline. The pipeline advances as one unit
// and holds while a result sits unclaimed in the output register.
// Reset restores mid-scale windows, clears sums, phase and result index.
// ----------------------------------------------------------------------------
module ecg_median5_decimator import emd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [23:0] ch1_code, [47:24] ch2_code, [71:48] ch3_code, [79:72] lead_off_bits
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [21:0] ch1_microvolt, [43:22] ch2_microvolt, [65:44] ch3_microvolt,
  // [87:66] mean_microvolt, [95:88] lead_off_out, [127:96] output_index
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);

  typedef struct packed {
    logic            vld;
    logic            emit;
    logic            two;
    logic [LO_W-1:0] lo;
  } stage_t;

  stage_t                 ctrl_q [1:PIPE_DEPTH];
  logic                   two_mode_q;
  logic [PHASE_W-1:0]     phase_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   adv, accept, emit;
  logic [CODE_W-1:0]      code [N_LANES];
  logic [SUM_W-1:0]       tot  [N_LANES];
  logic signed [UV_W-1:0] uv   [N_LANES];
  lane_ctl_t              lane_ctl [N_LANES];
  uv_res_t                res;

  assign m_axis_tvalid = ctrl_q[PIPE_DEPTH].vld & ctrl_q[PIPE_DEPTH].emit;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit          = (phase_q == PHASE_W'(DECIM - 1));
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= PIPE_DEPTH; k++) begin
        ctrl_q[k] <= '0;
      end
      two_mode_q <= 1'b0;
      phase_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        two_mode_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q <= emit ? '0 : phase_q + 1'b1;
      end
      if (adv) begin
        ctrl_q[1] <= '{vld: accept, emit: emit, two: two_mode_q,
                       lo: s_axis_tdata[N_LANES*CODE_W +: LO_W]};
        for (int k = 2; k <= PIPE_DEPTH; k++) begin
          ctrl_q[k] <= ctrl_q[k-1];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  for (genvar c = 0; c < N_LANES; c++) begin : g_lane
    logic act_in, act_med;

    assign code[c]  = s_axis_tdata[c*CODE_W +: CODE_W];
    assign act_in   = (c < N_LANES - 1) || !two_mode_q;
    assign act_med  = (c < N_LANES - 1) || !ctrl_q[STG_MED].two;

    assign lane_ctl[c] = '{adv: adv,
                           wr:  accept && act_in,
                           acc: ctrl_q[STG_MED].vld && act_med,
                           clr: ctrl_q[STG_MED].vld && ctrl_q[STG_MED].emit};

    emd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl[c]),
      .code_i (code[c]),
      .tot_o  (tot[c])
    );

    emd_uv_conv u_conv (
      .clk_i (clk_i),
      .adv_i (adv),
      .tot_i (tot[c]),
      .uv_o  (uv[c])
    );
  end

  emd_merge u_merge (
    .clk_i (clk_i),
    .adv_i (adv),
    .two_i (ctrl_q[STG_UV].two),
    .uv_i  (uv),
    .res_o (res)
  );

  assign m_axis_tdata = OUT_W'({idx_q, ctrl_q[PIPE_DEPTH].lo,
                                res.mean, res.ch3, res.ch2, res.ch1});

endmodule
